/* rtl/camera_ray_generator_top_macros.svh */
// Assertion macros for the camera ray generator.
// Used by camera_ray_generator_top; expects clk and arst_n in scope.
`ifndef CAMERA_RAY_GENERATOR_TOP_MACROS_SVH
`define CAMERA_RAY_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CRG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define CRG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/crg_pkg.sv */
// Package for the camera ray generator: beat types, basis build states,
// register indexes and rounding helper. No dependencies.
`default_nettype none

package crg_pkg;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
	} pix_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               degenerate;
	} ray_t;

	typedef enum logic [3:0] {
		B_FWD,
		B_FWD_W,
		B_DOT,
		B_W,
		B_UP,
		B_UP_W,
		B_CROSS,
		B_FOC,
		B_READY
	} bstate_t;

	localparam logic [2:0] REG_EYE    = 3'd0;
	localparam logic [2:0] REG_TARGET = 3'd1;
	localparam logic [2:0] REG_UP     = 3'd2;
	localparam logic [2:0] REG_FOCAL  = 3'd3;
	localparam logic [2:0] REG_MODE   = 3'd4;

	localparam logic [47:0] EYE_RESET    = 48'h0100_0000_0000;
	localparam logic [47:0] TARGET_RESET = 48'h0;
	localparam logic [47:0] UP_RESET     = 48'h0000_0100_0000;
	localparam logic [15:0] FOCAL_RESET  = 16'd256;

	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 15;

	// Side data that travels with a vector through the root and divide stages
	typedef struct packed {
		logic                  tag;
		logic                  zero;
		logic [2:0]            sgn;
		logic [2:0][22:0]      mag;
		logic [2:0][15:0]      org;
	} carry_t;

	// Shift right with rounding half away from zero
	function automatic logic signed [63:0] rsr(input logic signed [63:0] x, input int sh);
		logic [63:0] mag;
		logic [63:0] m;
		mag = x[63] ? 64'(-x) : 64'(x);
		m = (mag + (64'd1 << (sh - 1))) >> sh;
		return x[63] ? -$signed(m) : $signed(m);
	endfunction

endpackage

`default_nettype wire

/* rtl/camera_ray_generator_top.sv */
// Camera ray generator top level: basis builder, pixel pipeline, APB registers.
// Depends on crg_pkg and camera_ray_generator_top_macros.svh.
//
// Channel | Dir | Handshake         | Beat
// pix     | in  | pix_valid / stall | screen_x, screen_y (Q2.14)
// ray     | out | ray_valid / stall | origin xyz (Q8.8), dir xyz (Q2.14), degenerate
// apb     | in  | psel / penable    | five registers at 8*i, 64-bit data
//
// One beat per cycle while pix_stall and ray_stall are low. A pixel passes 54 register
// stages, most in the 32-step square root and 15-step divider of the normalize pipeline.
// After reset and after every register write the basis is rebuilt through the
// same pipeline, twice, with pix_stall high.
// A stalled ray holds the whole pipeline; nothing is lost or repeated.
`default_nettype none

`include "camera_ray_generator_top_macros.svh"

module camera_ray_generator_top import crg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire pix_t        pix,
	output logic             ray_valid,
	input  wire logic        ray_stall,
	output ray_t             ray,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	// configuration registers
	logic [47:0] eye_q, tgt_q, uph_q;
	logic [15:0] foc_q;
	logic        mode_q;
	logic        cfg_wr;

	// basis state
	bstate_t            bst_q, bst_n;
	logic               bf_q;
	logic               degb_q;
	logic signed [15:0] f_q [3];
	logic signed [15:0] u_q [3];
	logic signed [15:0] r_q [3];
	logic signed [37:0] ff_q [3];
	logic signed [31:0] dot_q;
	logic signed [23:0] w_q [3];

	logic signed [15:0] eye_c [3];
	logic signed [15:0] tgt_c [3];
	logic signed [15:0] uph_c [3];

	logic adv, issue, cap, pix_acc;
	logic signed [23:0] issue_vec [3];

	// front stages
	logic               v_s1, tag_s1;
	logic signed [15:0] x_s1, y_s1;
	logic signed [23:0] vec_s1 [3];
	logic               v_s2, tag_s2;
	logic signed [23:0] vec_s2 [3];
	logic signed [31:0] uy_s2 [3];
	logic signed [31:0] rx_s2 [3];
	logic               v_s3, tag_s3;
	logic signed [23:0] d_s3 [3];
	logic [15:0]        org_s3 [3];
	logic               v_s4, tag_s4;
	logic [45:0]        sq_s4 [3];
	logic [2:0]         sgn_s4;
	logic [22:0]        mag_s4 [3];
	logic [15:0]        org_s4 [3];

	// root and divide stages
	logic        v_sq [SQ_STEPS + 1];
	carry_t      c_sq [SQ_STEPS + 1];
	logic [63:0] rem_sq [SQ_STEPS + 1];
	logic [63:0] res_sq [SQ_STEPS + 1];
	logic [63:0] rem_n [SQ_STEPS];
	logic [63:0] res_n [SQ_STEPS];

	logic        v_dv [DV_STEPS + 1];
	carry_t      c_dv [DV_STEPS + 1];
	logic [32:0] den_dv [DV_STEPS + 1];
	logic [47:0] num_dv [DV_STEPS + 1][3];
	logic [14:0] q_dv [DV_STEPS + 1][3];
	logic [47:0] num_n [DV_STEPS][3];
	logic [14:0] q_n [DV_STEPS][3];

	logic               ray_valid_q;
	ray_t               ray_q;
	logic signed [15:0] qdir [3];

	// unpack configured vectors
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eye_c[i] = eye_q[16*i +: 16];
			tgt_c[i] = tgt_q[16*i +: 16];
			uph_c[i] = uph_q[16*i +: 16];
		end
	end

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[5:3])
			REG_EYE:    prdata = {16'd0, eye_q};
			REG_TARGET: prdata = {16'd0, tgt_q};
			REG_UP:     prdata = {16'd0, uph_q};
			REG_FOCAL:  prdata = {48'd0, foc_q};
			REG_MODE:   prdata = {63'd0, mode_q};
			default:    prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q  <= EYE_RESET;
			tgt_q  <= TARGET_RESET;
			uph_q  <= UP_RESET;
			foc_q  <= FOCAL_RESET;
			mode_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_EYE:    eye_q  <= pwdata[47:0];
				REG_TARGET: tgt_q  <= pwdata[47:0];
				REG_UP:     uph_q  <= pwdata[47:0];
				REG_FOCAL:  foc_q  <= pwdata[15:0];
				REG_MODE:   mode_q <= pwdata[0];
				default:    ;
			endcase
		end
	end

	// handshake: the whole pipeline moves unless the output beat is stalled
	assign adv       = !(ray_valid_q && ray_stall);
	assign pix_stall = !adv || (bst_q != B_READY);
	assign pix_acc   = pix_valid && !pix_stall;
	assign issue     = (bst_q == B_FWD || bst_q == B_UP) && !bf_q && adv;
	assign cap       = v_dv[DV_STEPS] && c_dv[DV_STEPS].tag && adv;

	// vector sent through the normalizer while building the basis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bst_q == B_FWD) begin
				issue_vec[i] = 24'(17'(tgt_c[i]) - 17'(eye_c[i]));
			end else begin
				issue_vec[i] = w_q[i];
			end
		end
	end

	// basis build sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_FWD;
			bf_q  <= 1'b0;
		end else begin
			bst_q <= bst_n;
			if (issue) begin
				bf_q <= 1'b1;
			end else if (cap) begin
				bf_q <= 1'b0;
			end
		end
	end

	always_comb begin
		bst_n = bst_q;
		case (bst_q)
			B_FWD:   if (issue) bst_n = B_FWD_W;
			B_FWD_W: if (cap) bst_n = B_DOT;
			B_DOT:   bst_n = B_W;
			B_W:     bst_n = B_UP;
			B_UP:    if (issue) bst_n = B_UP_W;
			B_UP_W:  if (cap) bst_n = B_CROSS;
			B_CROSS: bst_n = B_FOC;
			B_FOC:   bst_n = B_READY;
			B_READY: bst_n = B_READY;
			default: bst_n = B_FWD;
		endcase
		if (cfg_wr) begin
			bst_n = B_FWD;
		end
	end

	// signed normalized components at the end of the divider
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (c_dv[DV_STEPS].zero) begin
				qdir[i] = 16'sd0;
			end else if (c_dv[DV_STEPS].sgn[i]) begin
				qdir[i] = -$signed({1'b0, q_dv[DV_STEPS][i]});
			end else begin
				qdir[i] = $signed({1'b0, q_dv[DV_STEPS][i]});
			end
		end
	end

	// basis datapath, one step per sequencer state
	always_ff @(posedge clk) begin
		logic signed [47:0] wd;
		logic signed [63:0] wr;
		logic signed [31:0] cr;
		logic signed [63:0] rr;
		logic signed [32:0] fp;
		case (bst_q)
			B_FWD_W: begin
				if (cap) begin
					for (int i = 0; i < 3; i++) f_q[i] <= qdir[i];
					degb_q <= c_dv[DV_STEPS].zero;
				end
			end
			B_DOT: begin
				dot_q <= 32'(uph_c[0] * f_q[0]) + 32'(uph_c[1] * f_q[1])
					+ 32'(uph_c[2] * f_q[2]);
			end
			B_W: begin
				for (int i = 0; i < 3; i++) begin
					wd = (48'(uph_c[i]) <<< 28) - 48'(dot_q * f_q[i]);
					wr = rsr(64'(wd), 22);
					w_q[i] <= wr[23:0];
				end
			end
			B_UP_W: begin
				if (cap) begin
					for (int i = 0; i < 3; i++) u_q[i] <= qdir[i];
					degb_q <= degb_q | c_dv[DV_STEPS].zero;
				end
			end
			B_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					cr = 32'(f_q[(i + 1) % 3] * u_q[(i + 2) % 3])
						- 32'(f_q[(i + 2) % 3] * u_q[(i + 1) % 3]);
					rr = rsr(64'(cr), 14);
					if (rr > 64'sd16384) begin
						r_q[i] <= 16'sd16384;
					end else if (rr < -64'sd16384) begin
						r_q[i] <= -16'sd16384;
					end else begin
						r_q[i] <= rr[15:0];
					end
				end
			end
			B_FOC: begin
				for (int i = 0; i < 3; i++) begin
					fp = f_q[i] * $signed({1'b0, foc_q});
					ff_q[i] <= {fp[31:0], 6'd0};
				end
			end
			default: ;
		endcase
	end

	// valid bits of all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int j = 0; j <= SQ_STEPS; j++) v_sq[j] <= 1'b0;
			for (int k = 0; k <= DV_STEPS; k++) v_dv[k] <= 1'b0;
			ray_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_acc || issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sq[0] <= v_s4;
			for (int j = 0; j < SQ_STEPS; j++) v_sq[j + 1] <= v_sq[j];
			v_dv[0] <= v_sq[SQ_STEPS];
			for (int k = 0; k < DV_STEPS; k++) v_dv[k + 1] <= v_dv[k];
			ray_valid_q <= v_dv[DV_STEPS] && !c_dv[DV_STEPS].tag;
		end
	end

	// front stages: products, perspective sum, ortho origin, squares
	always_ff @(posedge clk) begin
		logic signed [39:0] ps;
		logic signed [63:0] pr;
		logic signed [32:0] ts;
		logic signed [63:0] tr;
		logic signed [17:0] os;
		logic signed [23:0] dv;
		if (adv) begin
			tag_s1 <= issue;
			x_s1   <= pix.screen_x;
			y_s1   <= pix.screen_y;
			for (int i = 0; i < 3; i++) vec_s1[i] <= issue_vec[i];

			tag_s2 <= tag_s1;
			for (int i = 0; i < 3; i++) begin
				vec_s2[i] <= vec_s1[i];
				uy_s2[i]  <= u_q[i] * y_s1;
				rx_s2[i]  <= r_q[i] * x_s1;
			end

			tag_s3 <= tag_s2;
			for (int i = 0; i < 3; i++) begin
				ps = 40'(ff_q[i]) + 40'(uy_s2[i]) + 40'(rx_s2[i]);
				pr = rsr(64'(ps), 14);
				d_s3[i] <= tag_s2 ? vec_s2[i] : pr[23:0];
				ts = 33'(rx_s2[i]) + 33'(uy_s2[i]);
				tr = rsr(64'(ts), 20);
				os = 18'(eye_c[i]) + tr[17:0];
				if (os > 18'sd32767) begin
					org_s3[i] <= 16'h7fff;
				end else if (os < -18'sd32768) begin
					org_s3[i] <= 16'h8000;
				end else begin
					org_s3[i] <= os[15:0];
				end
			end

			tag_s4 <= tag_s3;
			for (int i = 0; i < 3; i++) begin
				dv = d_s3[i];
				sgn_s4[i] <= dv[23];
				mag_s4[i] <= dv[23] ? 23'(-dv) : dv[22:0];
				sq_s4[i]  <= (dv[23] ? 23'(-dv) : dv[22:0]) * (dv[23] ? 23'(-dv) : dv[22:0]);
				org_s4[i] <= org_s3[i];
			end
		end
	end

	// one square-root digit per stage
	always_comb begin
		logic [63:0] bitc;
		logic [63:0] trial;
		for (int j = 0; j < SQ_STEPS; j++) begin
			bitc  = 64'd1 << (62 - 2 * j);
			trial = res_sq[j] + bitc;
			if (rem_sq[j] >= trial) begin
				rem_n[j] = rem_sq[j] - trial;
				res_n[j] = (res_sq[j] >> 1) + bitc;
			end else begin
				rem_n[j] = rem_sq[j];
				res_n[j] = res_sq[j] >> 1;
			end
		end
	end

	// one quotient bit per stage
	always_comb begin
		logic [47:0] dsh;
		for (int k = 0; k < DV_STEPS; k++) begin
			dsh = 48'(den_dv[k]) << (DV_STEPS - 1 - k);
			for (int i = 0; i < 3; i++) begin
				q_n[k][i] = q_dv[k][i];
				if (num_dv[k][i] >= dsh) begin
					num_n[k][i] = num_dv[k][i] - dsh;
					q_n[k][i][DV_STEPS - 1 - k] = 1'b1;
				end else begin
					num_n[k][i] = num_dv[k][i];
				end
			end
		end
	end

	// normalize pipeline registers
	always_ff @(posedge clk) begin
		logic [47:0] ssum;
		if (adv) begin
			ssum = 48'(sq_s4[0]) + 48'(sq_s4[1]) + 48'(sq_s4[2]);
			rem_sq[0]   <= {ssum, 16'd0};
			res_sq[0]   <= 64'd0;
			c_sq[0].tag  <= tag_s4;
			c_sq[0].zero <= (ssum == 48'd0);
			c_sq[0].sgn  <= sgn_s4;
			for (int i = 0; i < 3; i++) begin
				c_sq[0].mag[i] <= mag_s4[i];
				c_sq[0].org[i] <= org_s4[i];
			end
			for (int j = 0; j < SQ_STEPS; j++) begin
				rem_sq[j + 1] <= rem_n[j];
				res_sq[j + 1] <= res_n[j];
				c_sq[j + 1]   <= c_sq[j];
			end

			c_dv[0]   <= c_sq[SQ_STEPS];
			den_dv[0] <= {res_sq[SQ_STEPS][31:0], 1'b0};
			for (int i = 0; i < 3; i++) begin
				num_dv[0][i] <= 48'({c_sq[SQ_STEPS].mag[i], 23'd0})
					+ 48'(res_sq[SQ_STEPS][31:0]);
				q_dv[0][i] <= 15'd0;
			end
			for (int k = 0; k < DV_STEPS; k++) begin
				c_dv[k + 1]   <= c_dv[k];
				den_dv[k + 1] <= den_dv[k];
				for (int i = 0; i < 3; i++) begin
					num_dv[k + 1][i] <= num_n[k][i];
					q_dv[k + 1][i]   <= q_n[k][i];
				end
			end
		end
	end

	// output register: pick perspective or orthographic result
	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode_q) begin
				ray_q.origin_x   <= eye_c[0];
				ray_q.origin_y   <= eye_c[1];
				ray_q.origin_z   <= eye_c[2];
				ray_q.dir_x      <= degb_q ? 16'sd0 : qdir[0];
				ray_q.dir_y      <= degb_q ? 16'sd0 : qdir[1];
				ray_q.dir_z      <= degb_q ? 16'sd0 : qdir[2];
				ray_q.degenerate <= degb_q || c_dv[DV_STEPS].zero;
			end else begin
				ray_q.origin_x   <= c_dv[DV_STEPS].org[0];
				ray_q.origin_y   <= c_dv[DV_STEPS].org[1];
				ray_q.origin_z   <= c_dv[DV_STEPS].org[2];
				ray_q.dir_x      <= degb_q ? 16'sd0 : f_q[0];
				ray_q.dir_y      <= degb_q ? 16'sd0 : f_q[1];
				ray_q.dir_z      <= degb_q ? 16'sd0 : f_q[2];
				ray_q.degenerate <= degb_q;
			end
		end
	end

	assign ray_valid = ray_valid_q;
	assign ray       = ray_q;

	// checks
	`CRG_ASSERT_IMP(a_stall_in_build, bst_q != B_READY, pix_stall, "pixel taken during basis build")
	`CRG_ASSERT_IMP(a_cap_owned, cap, bf_q, "basis result with no basis vector in flight")
	`CRG_ASSERT_NXT(a_issue_marks, issue, bf_q, "basis vector issued but not marked in flight")

endmodule

`default_nettype wire
